// ===== design/nmtx_pkg.sv =====
package nmtx_pkg;

  localparam int MaxMutexesDef = 16;
  localparam int QueueDepthDef = 16;
  localparam int NameBytesDef  = 8;
  localparam int PidBitsDef    = 16;

  localparam logic [1:0] ReqCreate  = 2'd0;
  localparam logic [1:0] ReqLock    = 2'd1;
  localparam logic [1:0] ReqRelease = 2'd2;

  localparam logic [2:0] StDone    = 3'd0;
  localparam logic [2:0] StQueued  = 3'd1;
  localparam logic [2:0] StUnknown = 3'd2;
  localparam logic [2:0] StExists  = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;
  localparam logic [2:0] StQfull   = 3'd5;

endpackage

// ===== design/nmtx_wait_q.sv =====
// Waiter store: one circular queue of QUEUE_DEPTH pids per mutex slot,
// one write port and one registered read port.
module nmtx_wait_q #(
  parameter int  MAX_MUTEXES = nmtx_pkg::MaxMutexesDef,
  parameter int  QUEUE_DEPTH = nmtx_pkg::QueueDepthDef,
  parameter int  PID_BITS    = nmtx_pkg::PidBitsDef,
  localparam int SlotW       = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1,
  localparam int HeadW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int LenW        = $clog2(QUEUE_DEPTH + 1),
  localparam int PidW        = (PID_BITS < 16) ? PID_BITS : 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [HeadW-1:0] head_i,
  input  logic [LenW-1:0]  wr_pos_i,
  input  logic [LenW-1:0]  rd_pos_i,
  input  logic [PidW-1:0]  wdata_i,
  output logic [PidW-1:0]  rdata_o
);
  import nmtx_pkg::*;

  localparam int Depth  = MAX_MUTEXES * QUEUE_DEPTH;
  localparam int WAddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SumW   = LenW + 1;

  logic [PidW-1:0]   mem [Depth];
  logic [WAddrW-1:0] base;
  logic [WAddrW-1:0] waddr;
  logic [WAddrW-1:0] raddr;
  logic [PidW-1:0]   rd_q;

  // head + pos stays below twice the depth: one compare and subtract
  function automatic logic [HeadW-1:0] wrap_off(input logic [HeadW-1:0] head,
                                                input logic [LenW-1:0]  pos);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(pos);
    if (sum >= SumW'(QUEUE_DEPTH)) begin
      sum = sum - SumW'(QUEUE_DEPTH);
    end
    return HeadW'(sum);
  endfunction

  assign base  = WAddrW'(slot_i) * WAddrW'(QUEUE_DEPTH);
  assign waddr = base + WAddrW'(wrap_off(head_i, wr_pos_i));
  assign raddr = base + WAddrW'(wrap_off(head_i, rd_pos_i));

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr] <= wdata_i;
    end
    rd_q <= mem[raddr];
  end

  assign rdata_o = rd_q;

endmodule

// ===== design/named_mutex_table_with_wait_queues.sv =====
// Lock manager: a table of named mutexes, each with a lock flag and a FIFO of
// waiting pids. One item is handled at a time; in_stall_o is high while it is
// in work. An accepted item scans the name table, comparing one entry per
// cycle through the single name memory read port, up to the current mutex
// count; a name that is not in the table, including a new create, ends the
// scan when the index reaches the count. A lock or release on a found name
// then reads the mutex control word; a lock on a held mutex also compares
// one waiter per cycle in its queue, and a release with waiters reads the
// woken pid. A reserved type goes straight to the output step, which holds
// the item while the output stalls. Names end at their first zero byte. No
// clearing pass is needed after reset.
module named_mutex_table_with_wait_queues #(
  parameter int  MAX_MUTEXES = nmtx_pkg::MaxMutexesDef,
  parameter int  QUEUE_DEPTH = nmtx_pkg::QueueDepthDef,
  parameter int  NAME_BYTES  = nmtx_pkg::NameBytesDef,
  parameter int  PID_BITS    = nmtx_pkg::PidBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] mutex_name_i,
  input  logic [15:0] caller_pid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        wake_valid_o,
  output logic [15:0] wake_pid_o,
  output logic [3:0]  mutex_slot_o
);
  import nmtx_pkg::*;

  localparam int SlotW = (MAX_MUTEXES > 1) ? $clog2(MAX_MUTEXES) : 1;
  localparam int CntW  = $clog2(MAX_MUTEXES + 1);
  localparam int HeadW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LenW  = $clog2(QUEUE_DEPTH + 1);
  localparam int CtlW  = 1 + HeadW + LenW;
  localparam int PidW  = (PID_BITS < 16) ? PID_BITS : 16;
  localparam int NameW = 8 * NAME_BYTES;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SCtl   = 3'd2;
  localparam logic [2:0] SOp    = 3'd3;
  localparam logic [2:0] SQscan = 3'd4;
  localparam logic [2:0] SWake  = 3'd5;
  localparam logic [2:0] SFin   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       type_q, type_d;
  logic [NameW-1:0] name_q, name_d;
  logic [PidW-1:0]  pid_q, pid_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic [2:0]       rstat_q, rstat_d;
  logic             rwv_q, rwv_d;
  logic [PidW-1:0]  rwp_q, rwp_d;
  logic [3:0]       rslot_q, rslot_d;

  logic             out_valid_q;
  logic [2:0]       status_q;
  logic             wake_valid_q;
  logic [15:0]      wake_pid_q;
  logic [3:0]       mutex_slot_q;

  logic [NameW-1:0] name_mem [MAX_MUTEXES];
  logic [NameW-1:0] name_rd_q;
  logic [SlotW-1:0] name_raddr;
  logic             name_we;

  // per slot: {lock, head, length}
  logic [CtlW-1:0]  ctl_mem [MAX_MUTEXES];
  logic [CtlW-1:0]  ctl_rd_q;
  logic             ctl_we;
  logic [SlotW-1:0] ctl_waddr;
  logic [CtlW-1:0]  ctl_wdata;

  logic             q_lock;
  logic [HeadW-1:0] q_head;
  logic [LenW-1:0]  q_len;
  logic [HeadW:0]   head_inc;
  logic [HeadW-1:0] head_next;

  logic             wq_we;
  logic [PidW-1:0]  wq_rdata;
  logic             accept;
  logic             out_space;

  function automatic logic [NameW-1:0] canon(input logic [63:0] raw);
    logic [NameW-1:0] r;
    logic             live;
    r    = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return r;
  endfunction

  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_space  = !out_valid_q || !out_stall_i;

  assign q_lock    = ctl_rd_q[CtlW-1];
  assign q_head    = ctl_rd_q[LenW +: HeadW];
  assign q_len     = ctl_rd_q[LenW-1:0];
  assign head_inc  = {1'b0, q_head} + (HeadW+1)'(1);
  assign head_next = (head_inc == (HeadW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[HeadW-1:0];

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    type_d    = type_q;
    name_d    = name_q;
    pid_d     = pid_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    pos_d     = pos_q;
    rstat_d   = rstat_q;
    rwv_d     = rwv_q;
    rwp_d     = rwp_q;
    rslot_d   = rslot_q;
    name_we   = 1'b0;
    ctl_we    = 1'b0;
    ctl_waddr = slot_q;
    ctl_wdata = ctl_rd_q;
    wq_we     = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          type_d  = req_type_i;
          name_d  = canon(mutex_name_i);
          pid_d   = caller_pid_i[PidW-1:0];
          idx_d   = '0;
          rstat_d = StDone;
          rwv_d   = 1'b0;
          rwp_d   = '0;
          rslot_d = '0;
          case (req_type_i) inside
            ReqCreate, ReqLock, ReqRelease: state_d = SScan;
            default:                        state_d = SFin;
          endcase
        end
      end
      SScan: begin
        if (idx_q >= cnt_q) begin
          if (type_q == ReqCreate) begin
            if (cnt_q >= CntW'(MAX_MUTEXES)) begin
              rstat_d = StFull;
            end else begin
              name_we   = 1'b1;
              ctl_we    = 1'b1;
              ctl_waddr = cnt_q[SlotW-1:0];
              ctl_wdata = '0;
              cnt_d     = cnt_q + CntW'(1);
              rslot_d   = 4'(cnt_q);
            end
          end else begin
            rstat_d = StUnknown;
          end
          state_d = SFin;
        end else if (name_rd_q == name_q) begin
          slot_d  = idx_q[SlotW-1:0];
          rslot_d = 4'(idx_q);
          if (type_q == ReqCreate) begin
            rstat_d = StExists;
            state_d = SFin;
          end else begin
            state_d = SCtl;
          end
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      SCtl: begin
        // control word of slot_q lands in ctl_rd_q
        state_d = SOp;
      end
      SOp: begin
        pos_d  = '0;
        ctl_we = 1'b1;
        if (type_q == ReqRelease) begin
          if (q_len != '0) begin
            ctl_wdata = {1'b0, head_next, q_len - LenW'(1)};
            rwv_d     = 1'b1;
            state_d   = SWake;
          end else begin
            ctl_wdata = {1'b0, q_head, q_len};
            state_d   = SFin;
          end
        end else if (!q_lock) begin
          ctl_wdata = {1'b1, q_head, q_len};
          state_d   = SFin;
        end else begin
          ctl_we  = 1'b0;
          state_d = SQscan;
        end
      end
      SQscan: begin
        if (pos_q >= q_len) begin
          if (q_len >= LenW'(QUEUE_DEPTH)) begin
            rstat_d = StQfull;
          end else begin
            wq_we     = 1'b1;
            ctl_we    = 1'b1;
            ctl_wdata = {q_lock, q_head, q_len + LenW'(1)};
            rstat_d   = StQueued;
          end
          state_d = SFin;
        end else if (wq_rdata == pid_q) begin
          rstat_d = StQueued;
          state_d = SFin;
        end else begin
          pos_d = pos_q + LenW'(1);
        end
      end
      SWake: begin
        rwp_d   = wq_rdata;
        state_d = SFin;
      end
      SFin: begin
        if (out_space) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign name_raddr = (idx_d < CntW'(MAX_MUTEXES)) ? idx_d[SlotW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[cnt_q[SlotW-1:0]] <= name_q;
    end
    name_rd_q <= name_mem[name_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_we) begin
      ctl_mem[ctl_waddr] <= ctl_wdata;
    end
    ctl_rd_q <= ctl_mem[slot_q];
  end

  nmtx_wait_q #(
    .MAX_MUTEXES(MAX_MUTEXES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PID_BITS   (PID_BITS)
  ) u_wait_q (
    .clk_i   (clk_i),
    .we_i    (wq_we),
    .slot_i  (slot_q),
    .head_i  (q_head),
    .wr_pos_i(pos_q),
    .rd_pos_i(pos_d),
    .wdata_i (pid_q),
    .rdata_o (wq_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == SFin && out_space) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    name_q  <= name_d;
    pid_q   <= pid_d;
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    pos_q   <= pos_d;
    rstat_q <= rstat_d;
    rwv_q   <= rwv_d;
    rwp_q   <= rwp_d;
    rslot_q <= rslot_d;
    if (state_q == SFin && out_space) begin
      status_q     <= rstat_q;
      wake_valid_q <= rwv_q;
      wake_pid_q   <= 16'(rwp_q);
      mutex_slot_q <= rslot_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign wake_valid_o = wake_valid_q;
  assign wake_pid_o   = wake_pid_q;
  assign mutex_slot_o = mutex_slot_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_MUTEXES))
    else $error("mutex count above table size");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFin && out_space) |=> out_valid_o)
    else $error("finished item not presented");

  a_wake_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wake_valid_o) |-> (status_o == StDone))
    else $error("wake-up with non-done status");

  a_qscan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SQscan) |-> (pos_q <= q_len))
    else $error("queue scan past queue length");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != SIdle))
    else $error("accepted item not taken into work");
`endif

endmodule

// ===== sim/named_mutex_table_with_wait_queues_tb.sv =====
`timescale 1ns / 100ps

module named_mutex_table_with_wait_queues_tb;
  import nmtx_pkg::*;

  localparam logic [1:0] ReqReserved = 2'd3;
  localparam int SlotCount    = MaxMutexesDef;
  localparam int WaitDepth    = QueueDepthDef;
  localparam int PoolNames    = 24;
  localparam int PoolPids     = 24;
  localparam int RandomItems  = 930;
  localparam int IdlePct      = 29;
  localparam int HoldCycles   = 250;
  localparam int DrainCycles  = 64;
  localparam int CycleLimit   = 600000;

  typedef struct packed {
    logic [2:0]  status;
    logic        wake_valid;
    logic [15:0] wake_pid;
    logic [3:0]  slot;
  } lock_result_t;

  class mutex_scoreboard;
    logic [63:0]  names [SlotCount];
    bit           locked [SlotCount];
    int unsigned  count;
    logic [15:0]  waiters [SlotCount * WaitDepth];
    int unsigned  head [SlotCount];
    int unsigned  len [SlotCount];
    lock_result_t expected_q [$];
    int unsigned  errors, reported, checked, wakeups;
    int unsigned  status_seen [8];

    function logic [63:0] canon(logic [63:0] raw);
      logic [63:0] c;
      c = '0;
      for (int b = 0; b < NameBytesDef; b++) begin
        if (raw[8*b +: 8] == 8'd0) break;
        c[8*b +: 8] = raw[8*b +: 8];
      end
      return c;
    endfunction

    function int find(logic [63:0] nm);
      for (int i = 0; i < count; i++) begin
        if (names[i] == nm) return i;
      end
      return -1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predict the result of one accepted request and update the table.
    function void note_request(logic [1:0] kind, logic [63:0] raw, logic [15:0] pid);
      logic [63:0]  nm;
      int           slot;
      int unsigned  s;
      bit           waiting;
      lock_result_t r;
      nm = canon(raw);
      slot = find(nm);
      r = '0;
      r.status = StDone;
      case (kind)
        ReqCreate: begin
          if (slot >= 0) begin
            r.status = StExists;
            r.slot = slot[3:0];
          end else if (count >= SlotCount) begin
            r.status = StFull;
          end else begin
            names[count] = nm;
            locked[count] = 1'b0;
            head[count] = 0;
            len[count] = 0;
            r.slot = count[3:0];
            count++;
          end
        end
        ReqLock, ReqRelease: begin
          if (slot < 0) begin
            r.status = StUnknown;
          end else begin
            s = slot;
            r.slot = slot[3:0];
            if (kind == ReqLock) begin
              if (!locked[s]) begin
                locked[s] = 1'b1;
              end else begin
                waiting = 1'b0;
                for (int i = 0; i < len[s]; i++) begin
                  if (waiters[s*WaitDepth + (head[s] + i) % WaitDepth] == pid) waiting = 1'b1;
                end
                if (waiting) begin
                  r.status = StQueued;
                end else if (len[s] >= WaitDepth) begin
                  r.status = StQfull;
                end else begin
                  waiters[s*WaitDepth + (head[s] + len[s]) % WaitDepth] = pid;
                  len[s]++;
                  r.status = StQueued;
                end
              end
            end else begin
              // release pops a waiter even when the lock was already free
              locked[s] = 1'b0;
              if (len[s] > 0) begin
                r.wake_valid = 1'b1;
                r.wake_pid = waiters[s*WaitDepth + head[s]];
                head[s] = (head[s] + 1) % WaitDepth;
                len[s]--;
              end
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(lock_result_t got);
      lock_result_t want;
      string        diffs;
      if (expected_q.size() == 0) begin
        errors++;
        reported++;
        if (reported <= 10)
          $display("%0t: unexpected result status=%0d wake=%0d/%h slot=%0d", $time,
                   got.status, got.wake_valid, got.wake_pid, got.slot);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_seen[want.status]++;
      if (want.wake_valid) wakeups++;
      diffs = "";
      if (got.status !== want.status) diffs = {diffs, " status"};
      if (got.wake_valid !== want.wake_valid) diffs = {diffs, " wake_valid"};
      if (got.wake_pid !== want.wake_pid) diffs = {diffs, " wake_pid"};
      if (got.slot !== want.slot) diffs = {diffs, " slot"};
      if (diffs != "") begin
        errors++;
        reported++;
        if (reported <= 10)
          $display("%0t: result %0d bad%s: exp st/wv/wp/sl %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                   $time, checked, diffs, want.status, want.wake_valid, want.wake_pid,
                   want.slot, got.status, got.wake_valid, got.wake_pid, got.slot);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [63:0] mutex_name = '0;
  logic [15:0] caller_pid = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        wake_valid;
  logic [15:0] wake_pid;
  logic [3:0]  mutex_slot;

  mutex_scoreboard sb;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  named_mutex_table_with_wait_queues i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .mutex_name_i (mutex_name),
    .caller_pid_i (caller_pid),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .wake_valid_o (wake_valid),
    .wake_pid_o   (wake_pid),
    .mutex_slot_o (mutex_slot)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once traffic is flowing
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && sb.checked >= 300) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{status, wake_valid, wake_pid, mutex_slot});
  end

  task automatic send_item(input logic [1:0] kind, input logic [63:0] raw,
                           input logic [15:0] pid);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IdlePct);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    mutex_name <= raw;
    caller_pid <= pid;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, raw, pid);
  endtask

  // fill bytes past the terminating zero with junk; they must be ignored
  function automatic logic [63:0] make_raw(logic [63:0] nm);
    int          n;
    logic [63:0] junk;
    n = 0;
    while (n < 8 && nm[8*n +: 8] != 8'd0) n++;
    junk = {$urandom, $urandom};
    if (n <= 6 && $urandom_range(1)) return nm | (junk & ({64{1'b1}} << (8*(n+1))));
    return nm;
  endfunction

  initial begin : stimulus
    logic [63:0] pool_names [PoolNames];
    logic [15:0] pool_pids [PoolPids];
    logic [63:0] nm;
    logic [15:0] pid;
    logic [1:0]  kind;
    int          n, nlen, roll, sel, create_pct, hot_a, hot_b;
    bit          focus;

    sb = new;
    pool_names[0] = '1;
    pool_names[1] = '0;
    pool_names[2] = 64'h4142;
    for (int i = 3; i < PoolNames; i++) begin
      nlen = $urandom_range(8);
      pool_names[i] = '0;
      for (int b = 0; b < nlen; b++) pool_names[i][8*b +: 8] = 8'($urandom_range(255, 1));
    end
    pool_pids[0] = 16'h0000;
    pool_pids[1] = 16'hFFFF;
    for (int i = 2; i < PoolPids; i++) pool_pids[i] = 16'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, reserved type, name edge cases, queue order
    send_item(ReqLock, 64'h0000_0000_0051_5251, 16'h1234);
    send_item(ReqRelease, 64'h0000_0000_0051_5251, 16'h1234);
    send_item(ReqReserved, '1, '1);
    send_item(ReqCreate, '1, 16'h0001);
    send_item(ReqCreate, '0, 16'h0002);
    send_item(ReqCreate, 64'hA5A5_5A5A_C3C3_3C00, 16'h0003);
    send_item(ReqCreate, 64'h00DE_AD00_BE00_4142, 16'h0004);
    send_item(ReqLock, '1, 16'h0000);
    send_item(ReqLock, '1, 16'hFFFF);
    send_item(ReqLock, '1, 16'hFFFF);
    send_item(ReqLock, '1, 16'h0000);
    send_item(ReqRelease, '1, 16'h7777);
    send_item(ReqRelease, '1, 16'h7777);
    send_item(ReqRelease, '1, 16'h7777);
    send_item(ReqLock, 64'hFF00_0000_0000_4142, 16'h5555);
    send_item(ReqLock, 64'h0000_0000_0000_4142, 16'hAAAA);
    send_item(ReqReserved, '1, 16'h0000);
    send_item(ReqRelease, 64'h1234_5678_9ABC_DE00, 16'h0000);
    send_item(ReqRelease, 64'h4142, 16'h0000);
    send_item(ReqRelease, 64'h4142, 16'h0000);

    focus = 1'b0;
    hot_a = 0;
    hot_b = 0;
    for (n = 0; n < RandomItems; n++) begin
      // alternate spread traffic with phases that pile waiters on two mutexes
      if (n % 80 == 0) begin
        focus = ((n / 80) % 2 == 1);
        if (sb.count > 0) begin
          hot_a = $urandom_range(sb.count - 1);
          hot_b = $urandom_range(sb.count - 1);
        end
      end
      quiet = (n >= 600 && n < 750);
      if (n == 450) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end

      roll = $urandom_range(99);
      create_pct = (n < 80) ? 25 : 4;
      if (roll < 3) kind = ReqReserved;
      else if (roll < 3 + create_pct) kind = ReqCreate;
      else if (focus) kind = ($urandom_range(99) < 78) ? ReqLock : ReqRelease;
      else kind = $urandom_range(1) ? ReqLock : ReqRelease;

      sel = $urandom_range(99);
      if (kind == ReqCreate) begin
        if (sel < 60) nm = make_raw(pool_names[$urandom_range(PoolNames - 1)]);
        else nm = {$urandom, $urandom};
      end else if (sel < 85 && sb.count > 0) begin
        if (focus) nm = make_raw(sb.names[$urandom_range(1) ? hot_a : hot_b]);
        else nm = make_raw(sb.names[$urandom_range(sb.count - 1)]);
      end else if (sel < 93) begin
        nm = make_raw(pool_names[$urandom_range(PoolNames - 1)]);
      end else begin
        nm = {$urandom, $urandom};
      end
      pid = ($urandom_range(99) < 70) ? pool_pids[$urandom_range(PoolPids - 1)] : 16'($urandom);
      send_item(kind, nm, pid);
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("tb: %0d requests checked, %0d wake-ups, %0d mutexes in table, %0d errors",
             sb.checked, sb.wakeups, sb.count, sb.errors);
    $display("tb: done %0d, queued %0d, unknown %0d, exists %0d, full %0d, queue full %0d",
             sb.status_seen[StDone], sb.status_seen[StQueued], sb.status_seen[StUnknown],
             sb.status_seen[StExists], sb.status_seen[StFull], sb.status_seen[StQfull]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
